// ----- rtl/ptc_pkg.sv -----
// Package for the precedence transitive closure block.
// Holds the function codes, the fixed field widths and the controller state type.
// Depends on nothing.
`default_nettype none

package ptc_pkg;

    localparam int ROW_W  = 64;
    localparam int NODE_W = 6;
    localparam int CNT_W  = 7;

    typedef enum logic [1:0] {
        FUNC_ADD     = 2'd0,
        FUNC_COMPUTE = 2'd1,
        FUNC_CLEAR   = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_WR,
        ST_LOAD,
        ST_SCAN,
        ST_WAIT,
        ST_WB
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/precedence_transitive_closure_top.sv -----
// Precedence transitive closure: edge matrix in a one-port-read, one-port-write RAM.
// Depends on ptc_pkg for function codes, widths and the state type.
//
// Usage. An item (i_func, i_from_node, i_to_node) is taken at a rising edge with
// start high and busy low. Add edge sets bit to_node of row from_node (ignored
// when either node is at or above the node count) by a read and a write back. Clear
// zeroes the matrix in the cycle it is taken. Compute closes the matrix in place
// row by row and, as each row finishes, puts it out for one cycle with o_valid
// high; o_last marks the row of node count minus one. The receiver cannot stall.
// Compute loads each row, then scans its columns one column a cycle, pausing at
// each followed column while that column's row is read from the RAM and ORed into
// the row; after the scan the row, with its own node bit set, is written back.
// The node count (i_cfg_wdata, taken when i_cfg_we is high) may be written only
// while busy is low; values above MAX_NODES act as MAX_NODES.
// Reset clears the per-row valid flags, so the matrix reads as all zero at
// once, and sets the node count to 64; no clearing pass is needed.
`default_nettype none

module precedence_transitive_closure_top #(
    parameter int MAX_NODES = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [1:0]                 i_func,
    input  wire logic [ptc_pkg::NODE_W-1:0] i_from_node,
    input  wire logic [ptc_pkg::NODE_W-1:0] i_to_node,
    input  wire logic                       i_cfg_we,
    input  wire logic [ptc_pkg::CNT_W-1:0]  i_cfg_wdata,
    output logic                            o_valid,
    output logic [ptc_pkg::NODE_W-1:0]      o_row_index,
    output logic [ptc_pkg::ROW_W-1:0]       o_row_bits,
    output logic                            o_last
);

    localparam int ADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam logic [ptc_pkg::CNT_W-1:0] MAX_CNT = ptc_pkg::CNT_W'(MAX_NODES);

    ptc_pkg::t_state r_state, n_state;

    logic [ptc_pkg::CNT_W-1:0]  r_node_count;
    logic [ptc_pkg::ROW_W-1:0]  r_acc, n_acc;
    logic [ptc_pkg::NODE_W-1:0] r_i, n_i;
    logic [ptc_pkg::CNT_W-1:0]  r_j, n_j;

    logic [ptc_pkg::ROW_W-1:0] mem [MAX_NODES];
    logic [MAX_NODES-1:0]      r_valid;
    logic [ptc_pkg::ROW_W-1:0] r_rdata;
    logic                      r_rvalid;

    logic                      mem_re, mem_we, clr;
    logic [ADDR_W-1:0]         raddr, waddr;
    logic [ptc_pkg::ROW_W-1:0] wdata;
    logic [ptc_pkg::NODE_W-1:0] rnode;

    logic [ptc_pkg::CNT_W-1:0] eff;
    logic [ptc_pkg::ROW_W-1:0] mask, diag, row_q;
    logic accept, edge_ok, scan_done, follow, row_last;

    // effective node count and column mask
    assign eff  = (r_node_count > MAX_CNT) ? MAX_CNT : r_node_count;
    assign mask = (eff >= ptc_pkg::CNT_W'(ptc_pkg::ROW_W)) ? '1
                : ((ptc_pkg::ROW_W'(1) << eff) - ptc_pkg::ROW_W'(1));
    assign diag = ptc_pkg::ROW_W'(1) << r_i;
    assign row_q = r_rvalid ? r_rdata : '0;

    assign accept    = start && !busy;
    assign edge_ok   = ({1'b0, i_from_node} < eff) && ({1'b0, i_to_node} < eff);
    assign scan_done = (r_j == eff);
    assign follow    = r_acc[r_j[ptc_pkg::NODE_W-1:0]] && (r_j[ptc_pkg::NODE_W-1:0] != r_i);
    assign row_last  = (({1'b0, r_i} + ptc_pkg::CNT_W'(1)) == eff);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptc_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_func)
                        ptc_pkg::FUNC_ADD:     if (edge_ok) n_state = ptc_pkg::ST_ADD_WR;
                        ptc_pkg::FUNC_COMPUTE: if (eff != '0) n_state = ptc_pkg::ST_LOAD;
                        default: ;
                    endcase
                end
            end
            ptc_pkg::ST_ADD_WR: n_state = ptc_pkg::ST_IDLE;
            ptc_pkg::ST_LOAD:   n_state = ptc_pkg::ST_SCAN;
            ptc_pkg::ST_SCAN: begin
                if (scan_done) n_state = ptc_pkg::ST_WB;
                else if (follow) n_state = ptc_pkg::ST_WAIT;
            end
            ptc_pkg::ST_WAIT:   n_state = ptc_pkg::ST_SCAN;
            ptc_pkg::ST_WB:     n_state = row_last ? ptc_pkg::ST_IDLE : ptc_pkg::ST_LOAD;
            default:            n_state = ptc_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        busy        = (r_state != ptc_pkg::ST_IDLE);
        o_valid     = (r_state == ptc_pkg::ST_WB);
        o_row_index = r_i;
        o_row_bits  = (r_acc | diag) & mask;
        o_last      = o_valid && row_last;
    end

    // datapath and RAM control
    always_comb begin
        n_acc  = r_acc;
        n_i    = r_i;
        n_j    = r_j;
        mem_re = 1'b0;
        mem_we = 1'b0;
        clr    = 1'b0;
        rnode  = '0;
        wdata  = r_acc | diag;
        unique case (r_state)
            ptc_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_func)
                        ptc_pkg::FUNC_ADD: begin
                            if (edge_ok) begin
                                mem_re = 1'b1;
                                rnode  = i_from_node;
                                n_i    = i_from_node;
                                n_j    = {1'b0, i_to_node};
                            end
                        end
                        ptc_pkg::FUNC_COMPUTE: begin
                            if (eff != '0) begin
                                mem_re = 1'b1;
                                n_i    = '0;
                            end
                        end
                        ptc_pkg::FUNC_CLEAR: clr = 1'b1;
                        default: ;
                    endcase
                end
            end
            ptc_pkg::ST_ADD_WR: begin
                mem_we = 1'b1;
                wdata  = row_q | (ptc_pkg::ROW_W'(1) << r_j[ptc_pkg::NODE_W-1:0]);
            end
            ptc_pkg::ST_LOAD: begin
                n_acc = row_q;
                n_j   = '0;
            end
            ptc_pkg::ST_SCAN: begin
                if (!scan_done) begin
                    if (follow) begin
                        mem_re = 1'b1;
                        rnode  = r_j[ptc_pkg::NODE_W-1:0];
                    end else begin
                        n_j = r_j + ptc_pkg::CNT_W'(1);
                    end
                end
            end
            ptc_pkg::ST_WAIT: begin
                // rows above the count are never followed; mask their stale columns
                n_acc = r_acc | (row_q & mask);
                n_j   = r_j + ptc_pkg::CNT_W'(1);
            end
            ptc_pkg::ST_WB: begin
                mem_we = 1'b1;
                if (!row_last) begin
                    n_i    = r_i + ptc_pkg::NODE_W'(1);
                    mem_re = 1'b1;
                    rnode  = r_i + ptc_pkg::NODE_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign raddr = rnode[ADDR_W-1:0];
    assign waddr = r_i[ADDR_W-1:0];

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ptc_pkg::ST_IDLE;
            r_node_count <= ptc_pkg::CNT_W'(64);
            r_valid      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_node_count <= i_cfg_wdata;
            if (clr) r_valid <= '0;
            else if (mem_we) r_valid[waddr] <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_i   <= n_i;
        r_j   <= n_j;
    end

    // matrix RAM, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[waddr] <= wdata;
        if (mem_re) begin
            r_rdata  <= mem[raddr];
            r_rvalid <= r_valid[raddr];
        end
    end

`ifndef SYNTHESIS
    a_diag_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_row_bits[o_row_index])
        else $error("output row lacks its own node bit");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !busy)
        else $error("block still busy after last row");

    a_row_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> !o_valid && busy)
        else $error("rows not separated by a reload cycle");

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_func == ptc_pkg::FUNC_COMPUTE) && (eff != '0) |=> busy && !o_valid)
        else $error("compute word not started");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !o_valid)
        else $error("row strobe while idle");
`endif

endmodule

`default_nettype wire
